FILE: rtl/etf_pkg.sv
`default_nettype none

package etf_pkg;

    localparam int FRAC_BITS = 28;
    localparam int MAX_POWER = 8;
    localparam int MIN_POWER = 2;
    localparam int MAX_COLORS = 256;

    // Escape when |z|^2 > 4, with |z|^2 carrying 2*FRAC_BITS fraction bits.
    localparam logic [63:0] ESCAPE_LIMIT = 64'd4 << (2 * FRAC_BITS);
    localparam int THR_SHIFT = 2 * FRAC_BITS - 32;
    localparam logic [63:0] THR_CORR1 = 64'd186006703183;
    localparam logic [63:0] THR_CORR2 = 64'd120674321726177;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POWER      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLORS     = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQR,
        S_SQI,
        S_TEST,
        S_C1,
        S_C2,
        S_C3,
        S_C4,
        S_C5,
        S_ADD,
        S_REM,
        S_DONE
    } etf_state_t;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [7:0]  divisor;
    } etf_rem_req_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] remainder;
    } etf_rem_rsp_t;

    // Clamp a wide signed value into the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -38'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    // Fixed-point rescale of a raw product, rounding toward minus infinity.
    function automatic logic signed [37:0] fx(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> FRAC_BITS;
        return s[37:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/escape_time_fractal_pixel.sv
`default_nettype none

// Escape-time fractal pixel: one complex point in, one palette index out.
// The s_ channel carries a point (point_re, point_im, Q4.28) per word; the
// m_ channel returns one color_index word per point, 0 for a point that never
// escaped. The cfg channel writes the six setup registers by index and is
// always ready; write it only while no point is in flight.
// Per point the sequencer steps through S_SQR, S_SQI and S_TEST for |z|^2 and the
// escape test, then repeats S_C1..S_C5 power-1 times and ends in S_ADD for
// z = c + z^power, all through one 32x32 multiplier. An escaping point then
// waits in S_REM for the palette remainder, which runs bit-serially. One point
// is in work at a time.
// A finished index sits in the output register; the core can take the next
// point while that word waits, and it only stalls at its end when the
// output register is still full. Reset (aresetn low, synchronous) empties
// the output, idles the sequencer and restores the register defaults.
module escape_time_fractal_pixel (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_point_re,
    input  wire logic [31:0] s_point_im,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_color_index,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [etf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);
    import etf_pkg::*;

    logic        julia_mode_reg;
    logic [31:0] julia_re_reg, julia_im_reg;
    logic [15:0] max_iter_reg;
    logic [3:0]  power_reg;
    logic [8:0]  colors_reg;

    logic        idle, done, ack;
    logic [7:0]  color;
    logic [3:0]  pw_clamped;
    logic [7:0]  divisor;
    logic [31:0] c_re, c_im;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_color_reg, out_color_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            julia_mode_reg <= 1'b0;
            julia_re_reg   <= '0;
            julia_im_reg   <= '0;
            max_iter_reg   <= 16'd256;
            power_reg      <= 4'd2;
            colors_reg     <= 9'd16;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_JULIA_MODE: julia_mode_reg <= cfg_data[0];
                REG_JULIA_RE:   julia_re_reg   <= cfg_data;
                REG_JULIA_IM:   julia_im_reg   <= cfg_data;
                REG_MAX_ITER:   max_iter_reg   <= cfg_data[15:0];
                REG_POWER:      power_reg      <= cfg_data[3:0];
                REG_COLORS:     colors_reg     <= cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    // Out-of-range settings fold onto the nearest legal value.
    always_comb begin
        if (power_reg < 4'(MIN_POWER)) begin
            pw_clamped = 4'(MIN_POWER);
        end else if (power_reg > 4'(MAX_POWER)) begin
            pw_clamped = 4'(MAX_POWER);
        end else begin
            pw_clamped = power_reg;
        end
        if (colors_reg < 9'd2) begin
            divisor = 8'd1;
        end else if (colors_reg > 9'(MAX_COLORS)) begin
            divisor = 8'(MAX_COLORS - 1);
        end else begin
            divisor = 8'(colors_reg - 9'd1);
        end
    end

    // Mandelbrot mode uses the point as c; Julia mode uses the register pair.
    assign c_re = julia_mode_reg ? julia_re_reg : s_point_re;
    assign c_im = julia_mode_reg ? julia_im_reg : s_point_im;

    assign s_ready = idle;
    assign ack     = !out_valid_reg || m_ready;

    etf_iter u_iter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid && idle),
        .z0_re    (s_point_re),
        .z0_im    (s_point_im),
        .c_re     (c_re),
        .c_im     (c_im),
        .max_iter (max_iter_reg),
        .pw       (pw_clamped),
        .divisor  (divisor),
        .ack      (ack),
        .idle     (idle),
        .done     (done),
        .color    (color)
    );

    // Output register: refilled from the core when empty or being drained.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_color_next = out_color_reg;
        if (done && ack) begin
            out_valid_next = 1'b1;
            out_color_next = color;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_color_reg <= out_color_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_color_index = out_color_reg;

    // An accepted point keeps the core busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("core ready right after taking a point");

    // A new output word only appears when the core has finished.
    a_out_from_core: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |=> m_valid == $past(done))
        else $error("output word without a finished point");

    // The core never reports done while idle.
    a_done_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(done && idle))
        else $error("core done and idle together");

endmodule

`default_nettype wire

FILE: rtl/etf_mul.sv
`default_nettype none

module etf_mul (
    input  wire logic               aclk,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic signed [63:0]      prod_reg
);
    import etf_pkg::*;

    logic signed [63:0] prod_next;

    assign prod_next = 64'(a) * 64'(b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

FILE: rtl/etf_rem.sv
`default_nettype none

// Restoring division, one quotient bit per cycle; only the remainder is kept.
module etf_rem (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire etf_pkg::etf_rem_req_t req,
    output etf_pkg::etf_rem_rsp_t      rsp
);
    import etf_pkg::*;

    logic [15:0] quo_reg, quo_next;
    logic [8:0]  rem_reg, rem_next;
    logic [7:0]  div_reg, div_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [8:0]  trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[7:0], quo_reg[15]};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg != 5'd0) begin
            quo_next = {quo_reg[14:0], 1'b0};
            rem_next = (trial >= {1'b0, div_reg}) ? trial - {1'b0, div_reg} : trial;
            cnt_next = cnt_reg - 5'd1;
        end else if (busy_reg) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.valid     = busy_reg && cnt_reg == 5'd0;
    assign rsp.remainder = rem_reg[7:0];

endmodule

`default_nettype wire

FILE: rtl/etf_iter.sv
`default_nettype none

module etf_iter (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [31:0] z0_re,
    input  wire logic signed [31:0] z0_im,
    input  wire logic signed [31:0] c_re,
    input  wire logic signed [31:0] c_im,
    input  wire logic [15:0]        max_iter,
    input  wire logic [3:0]         pw,
    input  wire logic [7:0]         divisor,
    input  wire logic               ack,
    output logic                    idle,
    output logic                    done,
    output logic [7:0]              color
);
    import etf_pkg::*;

    etf_state_t state_reg, state_next;

    logic signed [31:0] zr_reg, zr_next, zi_reg, zi_next;
    logic signed [31:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [31:0] wr_reg, wr_next, wi_reg, wi_next;
    logic signed [31:0] nr_reg, nr_next;
    logic signed [37:0] t_reg, t_next;
    logic [63:0]        acc_reg, acc_next;
    logic [16:0]        k_reg, k_next;
    logic [15:0]        max_reg, max_next;
    logic [3:0]         pw_reg, pw_next;
    logic [3:0]         e_reg, e_next;
    logic [7:0]         div_reg, div_next;
    logic [7:0]         color_reg, color_next;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic [63:0]        mag;
    logic               escaped;
    logic [1:0]         corr;
    logic signed [17:0] diff;
    logic [3:0]         e_inc;

    etf_rem_req_t rem_req;
    etf_rem_rsp_t rem_rsp;

    etf_mul u_mul (
        .aclk     (aclk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    etf_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .rsp     (rem_rsp)
    );

    assign mag     = acc_reg + 64'(prod);
    assign escaped = mag > ESCAPE_LIMIT;
    assign e_inc   = e_reg + 4'd1;

    always_comb begin
        if ((mag >> THR_SHIFT) >= THR_CORR2) begin
            corr = 2'd2;
        end else if ((mag >> THR_SHIFT) >= THR_CORR1) begin
            corr = 2'd1;
        end else begin
            corr = 2'd0;
        end
        diff = $signed({1'b0, k_reg}) - $signed({16'd0, corr});
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (state_reg)
            S_SQR:   begin mul_a = zr_reg; mul_b = zr_reg; end
            S_SQI:   begin mul_a = zi_reg; mul_b = zi_reg; end
            S_C1:    begin mul_a = wr_reg; mul_b = zr_reg; end
            S_C2:    begin mul_a = wi_reg; mul_b = zi_reg; end
            S_C3:    begin mul_a = wr_reg; mul_b = zi_reg; end
            S_C4:    begin mul_a = wi_reg; mul_b = zr_reg; end
            default: begin mul_a = zr_reg; mul_b = zi_reg; end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = (max_iter == 16'd0) ? S_DONE : S_SQR;
                end
            end
            S_SQR:  state_next = S_SQI;
            S_SQI:  state_next = S_TEST;
            S_TEST: begin
                if (!escaped) begin
                    state_next = S_C1;
                end else if (diff < 0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_REM;
                end
            end
            S_C1:   state_next = S_C2;
            S_C2:   state_next = S_C3;
            S_C3:   state_next = S_C4;
            S_C4:   state_next = S_C5;
            S_C5:   state_next = (e_inc < pw_reg) ? S_C1 : S_ADD;
            S_ADD:  state_next = (k_reg[15:0] == max_reg) ? S_DONE : S_SQR;
            S_REM:  state_next = rem_rsp.valid ? S_DONE : S_REM;
            S_DONE: state_next = ack ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb begin
        zr_next = zr_reg;  zi_next = zi_reg;
        cr_next = cr_reg;  ci_next = ci_reg;
        wr_next = wr_reg;  wi_next = wi_reg;
        nr_next = nr_reg;  t_next  = t_reg;
        acc_next = acc_reg;
        k_next   = k_reg;
        max_next = max_reg;
        pw_next  = pw_reg;
        e_next   = e_reg;
        div_next = div_reg;
        color_next = color_reg;
        rem_req.start    = 1'b0;
        rem_req.dividend = diff[15:0];
        rem_req.divisor  = div_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    zr_next = z0_re;  zi_next = z0_im;
                    cr_next = c_re;   ci_next = c_im;
                    k_next  = 17'd1;
                    max_next = max_iter;
                    pw_next  = pw;
                    div_next = divisor;
                    color_next = '0;
                end
            end
            S_SQI: acc_next = 64'(prod);
            S_TEST: begin
                wr_next = zr_reg;
                wi_next = zi_reg;
                e_next  = 4'd1;
                if (escaped) begin
                    if (diff < 0) begin
                        // Truncating remainder of minus one.
                        color_next = (div_reg == 8'd1) ? 8'd1 : 8'd0;
                    end else begin
                        rem_req.start = 1'b1;
                    end
                end
            end
            S_C2: t_next  = fx(prod);
            S_C3: nr_next = sat32(t_reg - fx(prod));
            S_C4: t_next  = fx(prod);
            S_C5: begin
                wi_next = sat32(t_reg + fx(prod));
                wr_next = nr_reg;
                e_next  = e_inc;
            end
            S_ADD: begin
                zr_next = sat32(38'(cr_reg) + 38'(wr_reg));
                zi_next = sat32(38'(ci_reg) + 38'(wi_reg));
                k_next  = k_reg + 17'd1;
            end
            S_REM: begin
                if (rem_rsp.valid) begin
                    color_next = rem_rsp.remainder + 8'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        zr_reg <= zr_next;  zi_reg <= zi_next;
        cr_reg <= cr_next;  ci_reg <= ci_next;
        wr_reg <= wr_next;  wi_reg <= wi_next;
        nr_reg <= nr_next;  t_reg  <= t_next;
        acc_reg <= acc_next;
        k_reg   <= k_next;
        max_reg <= max_next;
        pw_reg  <= pw_next;
        e_reg   <= e_next;
        div_reg <= div_next;
        color_reg <= color_next;
    end

    assign idle  = state_reg == S_IDLE;
    assign done  = state_reg == S_DONE;
    assign color = color_reg;

endmodule

`default_nettype wire
